// ===== design/sweep_active_set_range_count_top_defines.svh =====
// Assertion macros shared by the sweep active set modules.
`ifndef SWEEP_ACTIVE_SET_RANGE_COUNT_TOP_DEFINES_SVH
`define SWEEP_ACTIVE_SET_RANGE_COUNT_TOP_DEFINES_SVH

// Check on every clock edge, reset included.
`define SASRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check on clock edges outside reset.
`define SASRC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// ===== design/sasrc_pkg.sv =====
// Types, codes and constants of the sweep active set block.
`default_nettype none
package sasrc_pkg;

  localparam int CAPACITY_DFLT = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;

  localparam int          HIT_W     = 7;
  localparam int          TOTAL_W   = 48;
  localparam int          HIT_MAX   = 127;
  localparam logic [47:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] y_low;
    logic signed [31:0] y_high;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  hit_count;
    logic [47:0] running_total;
    logic        status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_INS_WR,
    ST_FINISH,
    ST_DROP
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic mv_rd;
    logic mv_wr;
    logic ins_wr;
    logic finish;
    logic drop;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       scan_done;
    logic       match;
    logic       full;
    logic [1:0] cmd;
  } ctl_stat_t;

endpackage
`default_nettype wire

// ===== design/sasrc_dpath.sv =====
// Datapath: value store, fill count, scan compare, hit counter and running total.
`default_nettype none
`include "sweep_active_set_range_count_top_defines.svh"
module sasrc_dpath #(
  parameter int CAPACITY = sasrc_pkg::CAPACITY_DFLT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sasrc_pkg::in_word_t  in_word,
  input  wire sasrc_pkg::ctl_cmd_t  cmd,
  output sasrc_pkg::ctl_stat_t      stat,
  output logic                      out_strobe,
  output sasrc_pkg::out_word_t      out_word
);
  import sasrc_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int HW = (CW > HIT_W) ? CW : HIT_W;

  logic signed [31:0] mem [CAPACITY];

  logic [1:0]         cmd_r;
  logic signed [31:0] lo_r, hi_r;
  logic signed [31:0] rdata_r;
  logic [CW-1:0]      cnt_r, rd_idx_r, hits_r, last_idx;
  logic               cmp_vld_r;
  logic [AW-1:0]      cmp_idx_r, hit_at_r;
  logic [47:0]        total_r;
  logic               out_strobe_r;
  out_word_t          out_word_r;

  logic               issue, rd_en, we, eq_hit, in_range;
  logic [AW-1:0]      raddr, waddr;
  logic signed [31:0] wdata;
  logic [HW-1:0]      hits_ext;
  logic [6:0]         hit_sat;
  logic [48:0]        sum;
  logic [47:0]        total_nxt;

  assign last_idx = cnt_r - CW'(1);
  assign issue    = cmd.scan && (rd_idx_r < cnt_r);
  assign rd_en    = issue || cmd.mv_rd;
  assign raddr    = cmd.mv_rd ? last_idx[AW-1:0] : rd_idx_r[AW-1:0];
  assign we       = cmd.ins_wr || cmd.mv_wr;
  assign waddr    = cmd.ins_wr ? cnt_r[AW-1:0] : hit_at_r;
  assign wdata    = cmd.ins_wr ? lo_r : rdata_r;

  assign eq_hit   = cmp_vld_r && (rdata_r == lo_r) &&
                    ((cmd_r == CMD_INSERT) || (cmd_r == CMD_ERASE));
  assign in_range = (rdata_r >= lo_r) && (rdata_r <= hi_r);

  assign hits_ext = HW'(hits_r);
  assign hit_sat  = (hits_ext > HW'(HIT_MAX)) ? 7'(HIT_MAX) : hits_ext[6:0];
  assign sum      = {1'b0, total_r} + 49'(hits_r);
  assign total_nxt = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[47:0];

  assign stat.scan_done = (rd_idx_r == cnt_r) && !cmp_vld_r;
  assign stat.match     = eq_hit;
  assign stat.full      = (cnt_r == CW'(CAPACITY));
  assign stat.cmd       = cmd_r;

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_word.cmd;
      lo_r  <= in_word.y_low;
      hi_r  <= in_word.y_high;
    end
    cmp_idx_r <= rd_idx_r[AW-1:0];
    if (cmd.scan && eq_hit) begin
      hit_at_r <= cmp_idx_r;
    end
    if (cmd.finish) begin
      out_word_r.hit_count     <= (cmd_r == CMD_SEARCH) ? hit_sat : 7'd0;
      out_word_r.running_total <= (cmd_r == CMD_SEARCH) ? total_nxt : total_r;
      out_word_r.status        <= cmd.drop;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      rd_idx_r     <= '0;
      hits_r       <= '0;
      cmp_vld_r    <= 1'b0;
      total_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      cmp_vld_r    <= issue;
      out_strobe_r <= cmd.finish;
      if (cmd.load) begin
        rd_idx_r <= '0;
        hits_r   <= '0;
      end else begin
        if (issue) begin
          rd_idx_r <= rd_idx_r + CW'(1);
        end
        // Count a word inside the range as it leaves the compare stage.
        if (cmd.scan && cmp_vld_r && (cmd_r == CMD_SEARCH) && in_range) begin
          hits_r <= hits_r + CW'(1);
        end
      end
      if (cmd.ins_wr) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.mv_wr) begin
        cnt_r <= last_idx;
      end
      if (cmd.finish && (cmd_r == CMD_SEARCH)) begin
        total_r <= total_nxt;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  `SASRC_ASSERT_RST(a_cnt_bound, (cnt_r <= CW'(CAPACITY)), "fill count past capacity")
  `SASRC_ASSERT_RST(a_drop_no_hits, (out_strobe_r && out_word_r.status) |-> (out_word_r.hit_count == 7'd0), "dropped insert with hits")
  `SASRC_ASSERT_RST(a_total_mono, (total_r >= $past(total_r)), "running total went down")

endmodule
`default_nettype wire

// ===== design/sasrc_ctrl.sv =====
// Controller: sequences the scan, insert and erase steps of one word.
`default_nettype none
`include "sweep_active_set_range_count_top_defines.svh"
module sasrc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire sasrc_pkg::ctl_stat_t  stat,
  output sasrc_pkg::ctl_cmd_t        cmd,
  output logic                       busy
);
  import sasrc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.match) begin
          state_nxt = (stat.cmd == CMD_ERASE) ? ST_MOVE_RD : ST_FINISH;
        end else if (stat.scan_done) begin
          if (stat.cmd == CMD_INSERT) begin
            state_nxt = stat.full ? ST_DROP : ST_INS_WR;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_MOVE_RD: state_nxt = ST_MOVE_WR;
      ST_MOVE_WR: state_nxt = ST_FINISH;
      ST_INS_WR:  state_nxt = ST_FINISH;
      ST_FINISH:  state_nxt = ST_IDLE;
      ST_DROP:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN:    cmd.scan   = 1'b1;
      ST_MOVE_RD: cmd.mv_rd  = 1'b1;
      // Move the last stored value into the freed slot.
      ST_MOVE_WR: cmd.mv_wr  = 1'b1;
      ST_INS_WR:  cmd.ins_wr = 1'b1;
      ST_FINISH:  cmd.finish = 1'b1;
      ST_DROP: begin
        cmd.finish = 1'b1;
        cmd.drop   = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  `SASRC_ASSERT(a_reset_idle, (!rst_n) |=> (state_r == ST_IDLE), "not idle after reset")
  `SASRC_ASSERT_RST(a_start_scan, (state_r == ST_IDLE && start) |=> (state_r == ST_SCAN), "start not taken")
  `SASRC_ASSERT_RST(a_finish_once, (cmd.finish) |=> (state_r == ST_IDLE), "finish not followed by idle")

endmodule
`default_nettype wire

// ===== design/sweep_active_set_range_count_top.sv =====
// Each word scans the stored values, then strobes its result; an insert that stores adds
// a write step, and an insert or erase hit ends the scan, an erase hit adding a move of
// the last stored value. Busy stays high until the word finishes, so no new word is taken
// before then; the scan reads one word a cycle through the single read port of the value
// memory. Reset (synchronous, rst_n low) empties the store and clears the running total;
// the receiver cannot stall results.
`default_nettype none
module sweep_active_set_range_count_top #(
  parameter int CAPACITY = sasrc_pkg::CAPACITY_DFLT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire sasrc_pkg::in_word_t  in_word,
  output logic                      busy,
  output logic                      out_strobe,
  output sasrc_pkg::out_word_t      out_word
);
  import sasrc_pkg::*;

  ctl_cmd_t  ctl_cmd;
  ctl_stat_t ctl_stat;

  sasrc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (ctl_stat),
    .cmd   (ctl_cmd),
    .busy  (busy)
  );

  sasrc_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (ctl_cmd),
    .stat       (ctl_stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
`default_nettype wire

// ===== tb/sv/sweep_active_set_range_count_top_tb.sv =====
// Self-checking testbench of the sweep active set with range counting.
`timescale 1ns / 100ps
module sweep_active_set_range_count_top_tb;
  import sasrc_pkg::*;

  localparam int          STORE_DEPTH = CAPACITY_DFLT;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          POOL_SIZE   = 12;
  localparam int          FILL_COUNT  = STORE_DEPTH + 6;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          TAIL_CYCLES = STORE_DEPTH + 16;
  localparam logic [31:0] Y_MIN       = 32'h8000_0000;
  localparam logic [31:0] Y_MAX       = 32'h7fff_ffff;

  typedef struct {
    in_word_t word;
    bit       wait_drain;
    int       gap_after;
  } sweep_event_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_strobe;
  out_word_t out_word;

  sweep_event_t event_q[$];
  out_word_t    owed_q[$];

  // Shadow of the active set and the running total.
  logic [31:0] set_val [STORE_DEPTH];
  bit          set_used [STORE_DEPTH];
  logic [47:0] hit_sum = '0;

  logic [31:0] y_pool [POOL_SIZE];
  logic [31:0] fill_vals [FILL_COUNT];
  bit          steady_mode = 1'b0;

  bit took_word = 1'b0;
  int gap_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int n_insert = 0, n_search = 0, n_erase = 0, n_other = 0;
  int n_dropped = 0, n_results = 0, peak_hits = 0;

  sweep_active_set_range_count_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_word    (in_word),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one event to the shadow set and return the word it should produce.
  function automatic out_word_t apply_event(in_word_t w);
    out_word_t r;
    int        hit_at;
    int        free_at;
    int        n;
    r = '0;
    hit_at = -1;
    free_at = -1;
    n = 0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (set_used[i] && set_val[i] == w.y_low) hit_at = i;
      if (!set_used[i] && free_at < 0) free_at = i;
    end
    case (w.cmd)
      CMD_INSERT: begin
        if (hit_at < 0) begin
          if (free_at < 0) begin
            r.status = 1'b1;
          end else begin
            set_val[free_at] = w.y_low;
            set_used[free_at] = 1'b1;
          end
        end
      end
      CMD_ERASE: begin
        if (hit_at >= 0) set_used[hit_at] = 1'b0;
      end
      CMD_SEARCH: begin
        if (w.y_low <= w.y_high) begin
          for (int i = 0; i < STORE_DEPTH; i++) begin
            if (set_used[i] && $signed(set_val[i]) >= w.y_low &&
                $signed(set_val[i]) <= w.y_high) n++;
          end
        end
        if (48'(n) >= TOTAL_MAX - hit_sum) hit_sum = TOTAL_MAX;
        else hit_sum = hit_sum + 48'(n);
        r.hit_count = 7'((n > HIT_MAX) ? HIT_MAX : n);
      end
      default: ;
    endcase
    r.running_total = hit_sum;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly pool values and their neighbors so inserts and erases collide.
  function automatic logic [31:0] pick_y();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return y_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 8) return y_pool[$urandom_range(0, POOL_SIZE - 1)] + $urandom_range(0, 2) - 1;
    return $urandom();
  endfunction

  task automatic add_event(input logic [1:0] c, input logic [31:0] lo, input logic [31:0] hi,
                           input bit wait_drain);
    sweep_event_t e;
    e.word.cmd = c;
    e.word.y_low = lo;
    e.word.y_high = hi;
    e.wait_drain = wait_drain;
    e.gap_after = pick_gap();
    event_q.push_back(e);
  endtask

  // Driver: hold a word until taken, then idle or load the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took_word) begin
      // hold
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (event_q.size() > 0 && !(event_q[0].wait_drain && owed_q.size() > 0)) begin
      in_word <= event_q[0].word;
      gap_left <= event_q[0].gap_after;
      start <= 1'b1;
      void'(event_q.pop_front());
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check results first, then predict for a word taken at this edge.
  always @(posedge clk) begin
    out_word_t want;
    took_word <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_strobe) begin
        n_results++;
        if (owed_q.size() == 0) begin
          $error("result with nothing expected: hit_count %0d running_total %0d status %0d",
                 out_word.hit_count, out_word.running_total, out_word.status);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_word.hit_count !== want.hit_count) begin
            $error("hit_count: expected %0d, got %0d", want.hit_count, out_word.hit_count);
            fail_count++;
          end
          if (out_word.running_total !== want.running_total) begin
            $error("running_total: expected %0d, got %0d",
                   want.running_total, out_word.running_total);
            fail_count++;
          end
          if (out_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word.status);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        want = apply_event(in_word);
        owed_q.push_back(want);
        case (in_word.cmd)
          CMD_INSERT: n_insert++;
          CMD_SEARCH: n_search++;
          CMD_ERASE:  n_erase++;
          default:    n_other++;
        endcase
        if (want.status) n_dropped++;
        if (int'(want.hit_count) > peak_hits) peak_hits = want.hit_count;
      end
      if ((start && !busy) || out_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] lo, hi;
    int          r;

    for (int i = 0; i < STORE_DEPTH; i++) set_used[i] = 1'b0;

    // Extremes, duplicates, empty ranges, absent erases, unknown commands.
    add_event(CMD_INSERT, Y_MIN, 32'd0, 1'b0);
    add_event(CMD_INSERT, Y_MAX, 32'hffff_ffff, 1'b0);
    add_event(CMD_INSERT, 32'd0, 32'd0, 1'b0);
    add_event(CMD_INSERT, 32'hffff_ffff, 32'd0, 1'b0);
    add_event(CMD_INSERT, 32'd1, 32'd0, 1'b0);
    add_event(CMD_INSERT, 32'd0, $urandom(), 1'b0);
    add_event(CMD_SEARCH, Y_MIN, Y_MAX, 1'b0);
    add_event(CMD_SEARCH, Y_MAX, Y_MIN, 1'b0);
    add_event(CMD_SEARCH, 32'd0, 32'd0, 1'b0);
    add_event(CMD_SEARCH, Y_MIN, Y_MIN, 1'b0);
    add_event(CMD_SEARCH, Y_MAX, Y_MAX, 1'b0);
    add_event(CMD_SEARCH, 32'hffff_ffff, 32'd1, 1'b0);
    add_event(CMD_SEARCH, 32'd1, 32'hffff_ffff, 1'b0);
    add_event(CMD_ERASE, 32'd12345, 32'd0, 1'b0);
    add_event(CMD_ERASE, 32'hffff_ffff, 32'd0, 1'b0);
    add_event(CMD_SEARCH, Y_MIN, Y_MAX, 1'b0);
    add_event(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_event(CMD_UNUSED, $urandom(), $urandom(), 1'b0);
    add_event(CMD_ERASE, Y_MIN, 32'd0, 1'b0);
    add_event(CMD_ERASE, Y_MAX, 32'd0, 1'b0);
    add_event(CMD_ERASE, 32'd0, 32'd0, 1'b0);
    add_event(CMD_ERASE, 32'd1, 32'd0, 1'b0);
    add_event(CMD_SEARCH, Y_MIN, Y_MAX, 1'b0);

    // Fill past capacity after a full drain, then empty the store again.
    for (int i = 0; i < FILL_COUNT; i++) begin
      fill_vals[i] = $urandom();
      add_event(CMD_INSERT, fill_vals[i], $urandom(), i == 0);
    end
    add_event(CMD_INSERT, fill_vals[3], 32'd0, 1'b0);
    add_event(CMD_SEARCH, Y_MIN, Y_MAX, 1'b0);
    add_event(CMD_SEARCH, Y_MIN, 32'hffff_ffff, 1'b0);
    add_event(CMD_SEARCH, 32'd0, Y_MAX, 1'b0);
    add_event(CMD_SEARCH, $urandom(), $urandom(), 1'b0);
    steady_mode = 1'b1;
    for (int i = 0; i < FILL_COUNT; i++) add_event(CMD_ERASE, fill_vals[i], $urandom(), 1'b0);
    steady_mode = 1'b0;

    // Mixed phases, each with a fresh value pool; a few without idle gaps.
    for (int p = 0; p < 6; p++) begin
      steady_mode = (p % 3 == 1);
      for (int i = 0; i < POOL_SIZE; i++) y_pool[i] = $urandom();
      if (p % 2 == 0) begin
        y_pool[0] = Y_MIN;
        y_pool[1] = Y_MAX;
        y_pool[2] = 32'd0;
      end
      for (int i = 0; i < 40; i++) begin
        r = $urandom_range(0, 99);
        lo = pick_y();
        hi = pick_y();
        if (r < 40) begin
          add_event(CMD_INSERT, lo, hi, i == 0);
        end else if (r < 70) begin
          if ($urandom_range(0, 6) == 0) hi = lo;
          else if ($urandom_range(0, 6) == 0) begin
            lo = Y_MIN;
            hi = Y_MAX;
          end
          add_event(CMD_SEARCH, lo, hi, i == 0);
        end else if (r < 95) begin
          add_event(CMD_ERASE, lo, hi, i == 0);
        end else begin
          add_event(CMD_UNUSED, lo, hi, i == 0);
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (event_q.size() > 0 || start || owed_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_q.size() != 0) begin
      $error("%0d results never arrived", owed_q.size());
      fail_count++;
    end

    $display("Ran %0d inserts, %0d searches, %0d erases and %0d unknown commands.",
             n_insert, n_search, n_erase, n_other);
    $display("%0d results checked, %0d inserts dropped on a full store, peak hit count %0d.",
             n_results, n_dropped, peak_hits);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sasrc_pkg.sv
design/sasrc_dpath.sv
design/sasrc_ctrl.sv
design/sweep_active_set_range_count_top.sv
tb/sv/sweep_active_set_range_count_top_tb.sv
